// ===== rtl/core/max_tournament_tree_defines.svh =====
// Assertion macros used by the max tournament tree top level.
`ifndef MAX_TOURNAMENT_TREE_DEFINES_SVH
`define MAX_TOURNAMENT_TREE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define MTT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tournament tree check failed");
// Next-cycle implication, checked out of reset.
`define MTT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tournament tree check failed");
`else
`define MTT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MTT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/mtt_pkg.sv =====
// Shared constants, request codes and control structs of the max tournament tree.
`timescale 1ns / 1ps

package mtt_pkg;

    localparam int LEAF_COUNT_DEF = 512;
    localparam int VAL_W          = 16;
    localparam int KIND_W         = 2;

    // Request kinds; the remaining code is a no-op that reports the root
    typedef enum logic [KIND_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_POP  = 2'd1,
        REQ_DEC  = 2'd2
    } req_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic prep;
        logic cmp;
        logic out_load;
    } mtt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic              clr_last;
        logic [KIND_W-1:0] kind;
        logic              at_top;
    } mtt_sts_t;

endpackage

// ===== rtl/core/mtt_datapath.sv =====
// Datapath of the max tournament tree: leaf and node memories, path compare, result registers.
`timescale 1ns / 1ps

module mtt_datapath #(
    parameter int LEAF_COUNT = mtt_pkg::LEAF_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mtt_pkg::mtt_cmd_t                 cmd,
    output mtt_pkg::mtt_sts_t                 sts,
    input  logic [mtt_pkg::KIND_W-1:0]        in_kind,
    input  logic [$clog2(LEAF_COUNT)-1:0]     in_index,
    input  logic [mtt_pkg::VAL_W-1:0]         in_value,
    output logic [$clog2(LEAF_COUNT)-1:0]     top_index,
    output logic [mtt_pkg::VAL_W-1:0]         top_value
);
    import mtt_pkg::*;

    localparam int IDX_W = $clog2(LEAF_COUNT);
    localparam int ENT_W = VAL_W + IDX_W;

    // Request registers
    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [VAL_W-1:0]  val_reg;

    // Path walk: current child position (leaf positions have the top bit set)
    logic [IDX_W:0]    cp_reg;
    logic [ENT_W-1:0]  acc_reg;
    logic [ENT_W-1:0]  res_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [VAL_W-1:0]  out_val_reg;

    // Clearing sweep after reset
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  clr_cnt_next;
    logic [IDX_W-1:0]  clr_leaf_reg;
    logic [IDX_W-1:0]  clr_leaf_next;
    logic [IDX_W+1:0]  clr_stride_reg;
    logic [IDX_W+1:0]  clr_stride_next;

    // Memories
    logic [VAL_W-1:0]  leaf_mem [LEAF_COUNT];
    logic [ENT_W-1:0]  node_mem [LEAF_COUNT];
    logic [VAL_W-1:0]  leaf_q_reg;
    logic [ENT_W-1:0]  node_q_reg;

    logic              leaf_we;
    logic [IDX_W-1:0]  leaf_wa;
    logic [VAL_W-1:0]  leaf_wd;
    logic [IDX_W-1:0]  leaf_ra;
    logic              node_we;
    logic [IDX_W-1:0]  node_wa;
    logic [ENT_W-1:0]  node_wd;
    logic [IDX_W-1:0]  node_ra;

    logic              is_pop;
    logic              is_nop;
    logic [VAL_W-1:0]  dec_val;
    logic [VAL_W-1:0]  new_val;
    logic [IDX_W-1:0]  new_idx;
    logic [IDX_W-1:0]  parent;
    logic [ENT_W-1:0]  sib_ent;
    logic [ENT_W-1:0]  left_ent;
    logic [ENT_W-1:0]  right_ent;
    logic [ENT_W-1:0]  win_ent;

    assign is_pop = (kind_reg == REQ_POP);
    assign is_nop = (kind_reg != REQ_LOAD) && (kind_reg != REQ_POP) && (kind_reg != REQ_DEC);

    // Saturating decrement
    assign dec_val = (leaf_q_reg == '0) ? '0 : leaf_q_reg - VAL_W'(1);

    // New leaf value and the leaf it goes to
    always_comb
    begin
        case (kind_reg)
            REQ_POP:
            begin
                new_val = '0;
                new_idx = node_q_reg[IDX_W-1:0];
            end
            REQ_DEC:
            begin
                new_val = dec_val;
                new_idx = idx_reg;
            end
            default:
            begin
                new_val = val_reg;
                new_idx = idx_reg;
            end
        endcase
    end

    // One tree level: sibling against the entry carried up; right wins ties
    assign parent  = cp_reg[IDX_W:1];
    assign sib_ent = cp_reg[IDX_W] ? {leaf_q_reg, cp_reg[IDX_W-1:0] ^ IDX_W'(1)} : node_q_reg;

    always_comb
    begin
        if (cp_reg[0])
        begin
            left_ent  = sib_ent;
            right_ent = acc_reg;
        end
        else
        begin
            left_ent  = acc_reg;
            right_ent = sib_ent;
        end
        win_ent = (left_ent[ENT_W-1:IDX_W] > right_ent[ENT_W-1:IDX_W]) ? left_ent : right_ent;
    end

    // Memory addressing
    always_comb
    begin
        leaf_we = 1'b0;
        leaf_wa = new_idx;
        leaf_wd = new_val;
        if (cmd.clr_step)
        begin
            leaf_we = 1'b1;
            leaf_wa = clr_cnt_reg;
            leaf_wd = '0;
        end
        else if (cmd.prep && !is_nop)
        begin
            leaf_we = 1'b1;
        end
        leaf_ra = cmd.prep ? (new_idx ^ IDX_W'(1)) : idx_reg;

        node_we = 1'b0;
        node_wa = parent;
        node_wd = win_ent;
        if (cmd.clr_step)
        begin
            node_we = (clr_cnt_reg != '0);
            node_wa = clr_cnt_reg;
            node_wd = {{VAL_W{1'b0}}, clr_leaf_reg};
        end
        else if (cmd.cmp)
        begin
            node_we = 1'b1;
        end
        node_ra = cmd.cmp ? (parent ^ IDX_W'(1)) : IDX_W'(1);
    end

    // Leaf memory
    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_wa] <= leaf_wd;
        leaf_q_reg <= leaf_mem[leaf_ra];
    end

    // Node memory, entry 0 unused
    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_wa] <= node_wd;
        node_q_reg <= node_mem[node_ra];
    end

    // Sweep: node i holds the rightmost leaf below it; one level at a time
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg + IDX_W'(1);
        clr_stride_next = clr_stride_reg;
        clr_leaf_next   = clr_leaf_reg + clr_stride_reg[IDX_W-1:0];
        if ((clr_cnt_reg & clr_cnt_next) == '0)
        begin
            clr_stride_next = clr_stride_reg >> 1;
            clr_leaf_next   = IDX_W'((clr_stride_reg >> 1) - (IDX_W+2)'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            clr_leaf_reg   <= '0;
            clr_stride_reg <= (IDX_W+2)'(2 * LEAF_COUNT);
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg    <= clr_cnt_next;
            clr_leaf_reg   <= clr_leaf_next;
            clr_stride_reg <= clr_stride_next;
        end
    end

    // Request, path and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            idx_reg  <= in_index;
            val_reg  <= in_value;
        end
        if (cmd.prep)
        begin
            acc_reg <= {new_val, new_idx};
            cp_reg  <= {1'b1, new_idx};
            if (is_pop || is_nop)
                res_reg <= node_q_reg;
        end
        if (cmd.cmp)
        begin
            acc_reg <= win_ent;
            cp_reg  <= {1'b0, parent};
            if (sts.at_top && !is_pop)
                res_reg <= win_ent;
        end
        if (cmd.out_load)
        begin
            out_idx_reg <= res_reg[IDX_W-1:0];
            out_val_reg <= res_reg[ENT_W-1:IDX_W];
        end
    end

    assign sts.clr_last = (clr_cnt_reg == '1);
    assign sts.kind     = kind_reg;
    assign sts.at_top   = (parent == IDX_W'(1));

    assign top_index = out_idx_reg;
    assign top_value = out_val_reg;

endmodule

// ===== rtl/core/mtt_ctrl.sv =====
// Controller of the max tournament tree: sweep, request sequencing and output handshake.
`timescale 1ns / 1ps

module mtt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output mtt_pkg::mtt_cmd_t cmd,
    input  mtt_pkg::mtt_sts_t sts
);
    import mtt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_PREP,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   kind_nop;

    assign kind_nop = (sts.kind != REQ_LOAD) && (sts.kind != REQ_POP) && (sts.kind != REQ_DEC);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = kind_nop ? ST_DONE : ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (sts.at_top)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/core/max_tournament_tree.sv =====
// Top level of the max tournament tree: stream ports, controller and datapath.
`timescale 1ns / 1ps
`include "max_tournament_tree_defines.svh"

// Tournament tree over LEAF_COUNT (power of two) 16-bit counters that keeps the largest
// counter and its index at the root; ties go to the right, so the higher index wins.
// A request is load (write a counter), decrement (saturating at zero) or pop (report the
// root, then clear that counter); the remaining kind code only reports the root. Each
// request gives one result: the popped entry for pop, the root after the change otherwise.
// After reset a clearing pass initializes both memories; no request is taken meanwhile.
// A load, decrement or pop walks the path from the leaf up to the root, reading
// one sibling and writing one node per cycle through the node memory's read and
// write ports; the no-op kind skips the walk. One request is in work at a time; a
// new one is taken while the previous result still waits at the output.
module max_tournament_tree #(
    parameter int LEAF_COUNT = mtt_pkg::LEAF_COUNT_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // item_index, item_value
    input  logic [((($clog2(LEAF_COUNT) + mtt_pkg::VAL_W) + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic [mtt_pkg::KIND_W-1:0]                            s_tuser,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // top_index, top_value
    output logic [((($clog2(LEAF_COUNT) + mtt_pkg::VAL_W) + 7) / 8) * 8 - 1:0] m_tdata
);
    import mtt_pkg::*;

    localparam int IDX_W  = $clog2(LEAF_COUNT);
    localparam int DATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;

    mtt_cmd_t         cmd;
    mtt_sts_t         sts;
    logic [IDX_W-1:0] top_index;
    logic [VAL_W-1:0] top_value;

    mtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mtt_datapath #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_kind   (s_tuser),
        .in_index  (s_tdata[IDX_W-1:0]),
        .in_value  (s_tdata[IDX_W +: VAL_W]),
        .top_index (top_index),
        .top_value (top_value)
    );

    assign m_tdata = DATA_W'({top_value, top_index});

    // A finished result never overwrites one still waiting
    `MTT_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !m_tvalid || m_tready)
    // One request in work at a time
    `MTT_ASSERT_NXT(a_single_request, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // Tree stays untouched while waiting for a request
    `MTT_ASSERT_IMP(a_idle_quiet, clk, rst_n, s_tready, !cmd.cmp && !cmd.prep && !cmd.clr_step)

endmodule
